// ----- rtl/sams_pkg.sv -----
// shared types, constants and layout function for the shared-array multi-stack
`default_nettype none

package sams_pkg;

    localparam int DEPTH      = 64;
    localparam int MAX_STACKS = 4;

    localparam int WORD_W     = 32;
    localparam int AW         = $clog2(DEPTH);
    localparam int PW         = $clog2(DEPTH + 1);
    localparam int SID_W      = 2;
    localparam int K_W        = 3;
    localparam int BIW        = $clog2(MAX_STACKS + 2);
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int NRW        = (CFG_DATA_W > PW) ? CFG_DATA_W : PW;

    localparam logic [PW-1:0]  ARRAY_SIZE_RST  = PW'(64);
    localparam logic [K_W-1:0] STACK_COUNT_RST = K_W'(4);

    // reciprocal of three, 17 fractional bits
    localparam logic [16:0] THIRD_RECIP = 17'd43691;

    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_COUNT = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_WRITE,
        S_READ
    } t_state;

    typedef enum logic [1:0] {
        M_PLAIN,
        M_UP,
        M_DOWN
    } t_mode;

    // pointers held as position plus one, so an empty first stack sits at zero
    typedef logic [MAX_STACKS+1:0][PW-1:0] t_ptrs;

    typedef struct packed {
        logic           load;
        logic [K_W-1:0] count;
        t_ptrs          ptr;
    } t_layout;

    function automatic t_ptrs layout_ptrs(input logic [PW-1:0] n, input logic [K_W-1:0] k);
        logic [PW+16:0] prod;
        logic [PW-1:0]  slice;
        t_ptrs          ptrs;
        prod = (PW+17)'(n) * (PW+17)'(THIRD_RECIP);
        case (k)
            K_W'(2):  slice = n >> 1;
            K_W'(3):  slice = prod[PW+16:17];
            K_W'(4):  slice = n >> 2;
            default:  slice = n;
        endcase
        for (int s = 0; s < MAX_STACKS + 2; s++) begin
            ptrs[s] = (s < int'(k)) ? PW'(slice * s) : n;
        end
        return ptrs;
    endfunction

    // empty layout after reset
    localparam t_ptrs RST_PTRS = layout_ptrs(ARRAY_SIZE_RST, STACK_COUNT_RST);

endpackage

`default_nettype wire

// ----- rtl/sams_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none

module sams_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/sams_cfg.sv -----
// configuration registers with clamping and the empty stack layout they imply
`default_nettype none

module sams_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr,
    input  wire logic [sams_pkg::CFG_IDX_W-1:0]  i_index,
    input  wire logic [sams_pkg::CFG_DATA_W-1:0] i_data,
    output sams_pkg::t_layout                   o_layout
);

    logic [sams_pkg::PW-1:0]  r_array_size, n_array_size;
    logic [sams_pkg::K_W-1:0] r_stack_count, n_stack_count;
    logic [sams_pkg::K_W-1:0] raw_k;
    logic [sams_pkg::NRW-1:0] raw_n;
    logic [sams_pkg::NRW-1:0] clamp_n;
    logic                     hit;

    always_comb begin
        hit   = i_wr && ((i_index == sams_pkg::CFG_ARRAY_SIZE) ||
                         (i_index == sams_pkg::CFG_STACK_COUNT));
        raw_k = (i_index == sams_pkg::CFG_STACK_COUNT) ?
                sams_pkg::K_W'(i_data[2:0]) : r_stack_count;
        raw_n = (i_index == sams_pkg::CFG_ARRAY_SIZE) ?
                sams_pkg::NRW'(i_data) : sams_pkg::NRW'(r_array_size);

        if (raw_k == '0) begin
            n_stack_count = sams_pkg::K_W'(1);
        end else if (raw_k > sams_pkg::K_W'(sams_pkg::MAX_STACKS)) begin
            n_stack_count = sams_pkg::K_W'(sams_pkg::MAX_STACKS);
        end else begin
            n_stack_count = raw_k;
        end

        if (raw_n < sams_pkg::NRW'(n_stack_count)) begin
            clamp_n = sams_pkg::NRW'(n_stack_count);
        end else if (raw_n > sams_pkg::NRW'(sams_pkg::DEPTH)) begin
            clamp_n = sams_pkg::NRW'(sams_pkg::DEPTH);
        end else begin
            clamp_n = raw_n;
        end
        n_array_size = sams_pkg::PW'(clamp_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_array_size  <= sams_pkg::ARRAY_SIZE_RST;
            r_stack_count <= sams_pkg::STACK_COUNT_RST;
        end else if (hit) begin
            r_array_size  <= n_array_size;
            r_stack_count <= n_stack_count;
        end
    end

    always_comb begin
        o_layout.load  = hit;
        o_layout.count = r_stack_count;
        o_layout.ptr   = sams_pkg::layout_ptrs(n_array_size, n_stack_count);
    end

endmodule

`default_nettype wire

// ----- rtl/shared_array_multi_stack_core.sv -----
// top level: several stacks in one word ram, with neighbour borrowing on push
//
// usage
//   input: raise start with i_kind, i_stack_id and i_value; the command is taken
//   at a clock edge where start is high and busy is low. kind push, pop, peek.
//   result: o_done is high for exactly one cycle with o_status and o_read_value;
//   the receiver cannot stall, so a result is never held back.
//   config: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data, taken only
//   while busy is low; any write of array_size or stack_count rebuilds the empty
//   layout, words in the ram are kept.
// timing
//   rejected commands and kind 3: result registered in the cycle after acceptance, no busy.
//   plain push, pop, peek: the write or read state follows acceptance, and the
//   result is registered from it. borrowing push: the next stack's words, or
//   its own words when only the previous stack has room, move one per cycle
//   through the single ram read/write port pair, then the new word is written.
// reset
//   synchronous active-low reset gives array_size 64, stack_count 4, all stacks
//   empty; ram words are not cleared and their contents are never used before being written.
`default_nettype none

module shared_array_multi_stack_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic        [sams_pkg::KIND_W-1:0]    i_kind,
    input  wire logic        [sams_pkg::SID_W-1:0]     i_stack_id,
    input  wire logic signed [sams_pkg::WORD_W-1:0]    i_value,
    output logic                                       o_done,
    output logic             [sams_pkg::STATUS_W-1:0]  o_status,
    output logic signed      [sams_pkg::WORD_W-1:0]    o_read_value,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic        [sams_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic        [sams_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    sams_pkg::t_layout w_layout;

    logic [sams_pkg::PW-1:0] r_top  [sams_pkg::MAX_STACKS];
    logic [sams_pkg::PW-1:0] r_base [sams_pkg::MAX_STACKS+2];

    sams_pkg::t_state r_state, n_state;
    sams_pkg::t_mode  r_mode, n_mode;
    logic                              r_pop, n_pop;
    logic [sams_pkg::SID_W-1:0]        r_sid, n_sid;
    logic [sams_pkg::WORD_W-1:0]       r_value, n_value;
    logic [sams_pkg::AW-1:0]           r_ra, n_ra;
    logic [sams_pkg::AW-1:0]           r_pa, n_pa;
    logic [sams_pkg::AW-1:0]           r_wa, n_wa;
    logic [sams_pkg::PW-1:0]           r_cnt, n_cnt;
    logic                              r_pend, n_pend;
    logic                              r_done, n_done;
    logic [sams_pkg::STATUS_W-1:0]     r_status, n_status;
    logic [sams_pkg::WORD_W-1:0]       r_read_value, n_read_value;

    logic                              w_we;
    logic [sams_pkg::AW-1:0]           w_waddr, w_raddr;
    logic [sams_pkg::WORD_W-1:0]       w_wdata, w_rdata;

    logic                              w_accept, w_in_range, w_last, w_first;
    logic                              w_room_self, w_room_next, w_room_prev, w_pop_ok;
    logic [sams_pkg::PW-1:0]           cur_top, cur_b0, cur_b1, nxt_top, nxt_b2, prv_top;

    sams_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (i_cfg_valid && o_cfg_ready),
        .i_index  (i_cfg_index),
        .i_data   (i_cfg_data),
        .o_layout (w_layout)
    );

    sams_ram #(
        .WIDTH (sams_pkg::WORD_W),
        .DEPTH (sams_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign busy        = (r_state != sams_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == sams_pkg::S_IDLE);
    assign w_accept    = start && !busy;

    // pointer lookups for the requested stack and its neighbours
    always_comb begin
        cur_top     = r_top[i_stack_id];
        cur_b0      = r_base[sams_pkg::BIW'(i_stack_id)];
        cur_b1      = r_base[sams_pkg::BIW'(i_stack_id) + sams_pkg::BIW'(1)];
        nxt_top     = r_top[i_stack_id + sams_pkg::SID_W'(1)];
        nxt_b2      = r_base[sams_pkg::BIW'(i_stack_id) + sams_pkg::BIW'(2)];
        prv_top     = r_top[i_stack_id - sams_pkg::SID_W'(1)];
        w_in_range  = sams_pkg::K_W'(i_stack_id) < w_layout.count;
        w_last      = (sams_pkg::K_W'(i_stack_id) + sams_pkg::K_W'(1)) == w_layout.count;
        w_first     = (i_stack_id == '0);
        w_room_self = (cur_top != cur_b1);
        w_room_next = !w_last && (nxt_top != nxt_b2);
        w_room_prev = !w_first && (prv_top != cur_b0);
        w_pop_ok    = w_in_range && (cur_top != cur_b0);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sams_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_kind) inside
                        sams_pkg::KIND_PUSH: begin
                            if (w_in_range && w_room_self) begin
                                n_state = sams_pkg::S_WRITE;
                            end else if (w_in_range && (w_room_next || w_room_prev)) begin
                                n_state = sams_pkg::S_SHIFT;
                            end
                        end
                        sams_pkg::KIND_POP, sams_pkg::KIND_PEEK: begin
                            if (w_pop_ok) begin
                                n_state = sams_pkg::S_READ;
                            end
                        end
                        default: n_state = sams_pkg::S_IDLE;
                    endcase
                end
            end
            sams_pkg::S_SHIFT: begin
                if (r_cnt == '0) begin
                    n_state = sams_pkg::S_WRITE;
                end
            end
            sams_pkg::S_WRITE: n_state = sams_pkg::S_IDLE;
            sams_pkg::S_READ:  n_state = sams_pkg::S_IDLE;
            default:           n_state = sams_pkg::S_IDLE;
        endcase
    end

    // datapath, ram port and result outputs
    always_comb begin
        n_mode       = r_mode;
        n_pop        = r_pop;
        n_sid        = r_sid;
        n_value      = r_value;
        n_ra         = r_ra;
        n_pa         = r_pa;
        n_wa         = r_wa;
        n_cnt        = r_cnt;
        n_pend       = 1'b0;
        n_done       = 1'b0;
        n_status     = r_status;
        n_read_value = r_read_value;
        w_we         = 1'b0;
        w_waddr      = r_wa;
        w_wdata      = r_value;
        w_raddr      = r_ra;

        unique case (r_state)
            sams_pkg::S_IDLE: begin
                // top word of the requested stack, used by pop and peek
                w_raddr = sams_pkg::AW'(cur_top - sams_pkg::PW'(1));
                if (w_accept) begin
                    n_sid   = i_stack_id;
                    n_value = i_value;
                    n_pop   = (i_kind == sams_pkg::KIND_POP);
                    unique case (i_kind) inside
                        sams_pkg::KIND_PUSH: begin
                            if (w_in_range && w_room_self) begin
                                n_mode = sams_pkg::M_PLAIN;
                                n_wa   = sams_pkg::AW'(cur_top);
                            end else if (w_in_range && w_room_next) begin
                                // move the next stack up one word, top first
                                n_mode = sams_pkg::M_UP;
                                n_ra   = sams_pkg::AW'(nxt_top - sams_pkg::PW'(1));
                                n_cnt  = nxt_top - cur_b1;
                                n_wa   = sams_pkg::AW'(cur_top);
                            end else if (w_in_range && w_room_prev) begin
                                // move own words down one, bottom first
                                n_mode = sams_pkg::M_DOWN;
                                n_ra   = sams_pkg::AW'(cur_b0);
                                n_cnt  = cur_top - cur_b0;
                                n_wa   = sams_pkg::AW'(cur_top - sams_pkg::PW'(1));
                            end else begin
                                n_done       = 1'b1;
                                n_status     = sams_pkg::ST_OVERFLOW;
                                n_read_value = '0;
                            end
                        end
                        sams_pkg::KIND_POP, sams_pkg::KIND_PEEK: begin
                            if (!w_pop_ok) begin
                                n_done       = 1'b1;
                                n_status     = sams_pkg::ST_UNDERFLOW;
                                n_read_value = '0;
                            end
                        end
                        default: begin
                            n_done       = 1'b1;
                            n_status     = sams_pkg::ST_OK;
                            n_read_value = '0;
                        end
                    endcase
                end
            end
            sams_pkg::S_SHIFT: begin
                if (r_cnt != '0) begin
                    n_ra   = (r_mode == sams_pkg::M_UP) ?
                             r_ra - sams_pkg::AW'(1) : r_ra + sams_pkg::AW'(1);
                    n_cnt  = r_cnt - sams_pkg::PW'(1);
                    n_pend = 1'b1;
                    n_pa   = r_ra;
                end
                // write back the word read in the previous cycle
                w_we    = r_pend;
                w_waddr = (r_mode == sams_pkg::M_UP) ?
                          r_pa + sams_pkg::AW'(1) : r_pa - sams_pkg::AW'(1);
                w_wdata = w_rdata;
            end
            sams_pkg::S_WRITE: begin
                w_we         = 1'b1;
                w_waddr      = r_wa;
                w_wdata      = r_value;
                n_done       = 1'b1;
                n_status     = sams_pkg::ST_OK;
                n_read_value = '0;
            end
            sams_pkg::S_READ: begin
                n_done       = 1'b1;
                n_status     = sams_pkg::ST_OK;
                n_read_value = w_rdata;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sams_pkg::S_IDLE;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_pop        <= n_pop;
        r_sid        <= n_sid;
        r_value      <= n_value;
        r_ra         <= n_ra;
        r_pa         <= n_pa;
        r_wa         <= n_wa;
        r_cnt        <= n_cnt;
        r_status     <= n_status;
        r_read_value <= n_read_value;
    end

    // stack pointer file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < sams_pkg::MAX_STACKS; s++) begin
                r_top[s] <= sams_pkg::RST_PTRS[s];
            end
            for (int s = 0; s < sams_pkg::MAX_STACKS + 2; s++) begin
                r_base[s] <= sams_pkg::RST_PTRS[s];
            end
        end else if (w_layout.load) begin
            for (int s = 0; s < sams_pkg::MAX_STACKS; s++) begin
                r_top[s] <= w_layout.ptr[s];
            end
            for (int s = 0; s < sams_pkg::MAX_STACKS + 2; s++) begin
                r_base[s] <= w_layout.ptr[s];
            end
        end else begin
            case (r_state)
                sams_pkg::S_WRITE: begin
                    case (r_mode)
                        sams_pkg::M_PLAIN: begin
                            r_top[r_sid] <= r_top[r_sid] + sams_pkg::PW'(1);
                        end
                        sams_pkg::M_UP: begin
                            r_top[r_sid] <= r_top[r_sid] + sams_pkg::PW'(1);
                            r_top[r_sid + sams_pkg::SID_W'(1)] <=
                                r_top[r_sid + sams_pkg::SID_W'(1)] + sams_pkg::PW'(1);
                            r_base[sams_pkg::BIW'(r_sid) + sams_pkg::BIW'(1)] <=
                                r_base[sams_pkg::BIW'(r_sid) + sams_pkg::BIW'(1)] +
                                sams_pkg::PW'(1);
                        end
                        sams_pkg::M_DOWN: begin
                            r_base[sams_pkg::BIW'(r_sid)] <=
                                r_base[sams_pkg::BIW'(r_sid)] - sams_pkg::PW'(1);
                        end
                        default: begin
                            r_top[r_sid] <= r_top[r_sid];
                        end
                    endcase
                end
                sams_pkg::S_READ: begin
                    if (r_pop) begin
                        r_top[r_sid] <= r_top[r_sid] - sams_pkg::PW'(1);
                    end
                end
                default: begin
                    r_top[r_sid] <= r_top[r_sid];
                end
            endcase
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_read_value = r_read_value;

`ifndef SYNTHESIS
    // pop and peek read the ram while idle, so no write may land then
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sams_pkg::S_IDLE) |-> !w_we)
        else $error("ram written while idle");

    // a pending write-back always follows a read issued in the shift loop
    a_pend_from_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sams_pkg::S_SHIFT && r_pend) |->
        $past(r_state == sams_pkg::S_SHIFT && r_cnt != '0))
        else $error("shift write-back without a matching read");

    // a result only follows a transaction or work in progress
    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy || start))
        else $error("result strobe without a transaction");

    // first stack stays between its base and the next base
    a_stack0_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (r_base[0] <= r_top[0]) && (r_top[0] <= r_base[1]))
        else $error("stack 0 pointers out of order");
`endif

endmodule

`default_nettype wire

// ----- test/tb_shared_array_multi_stack_core.sv -----
// self-checking testbench for the shared-array multi-stack core
`default_nettype none

module tb_shared_array_multi_stack_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int SETTLE_CYCLES  = sams_pkg::DEPTH + 8;
    localparam int RANDOM_ROUNDS  = 16;
    localparam int ROUND_COMMANDS = 100;

    localparam logic [sams_pkg::KIND_W-1:0]    KIND_NONE     = 2'd3;
    localparam logic [sams_pkg::CFG_IDX_W-1:0] CFG_SPARE_LOW = 2'd2;
    localparam logic [sams_pkg::CFG_IDX_W-1:0] CFG_SPARE_TOP = 2'd3;

    typedef struct packed {
        logic [sams_pkg::STATUS_W-1:0] status;
        logic [sams_pkg::WORD_W-1:0]   read_value;
    } t_outcome;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic [sams_pkg::KIND_W-1:0]     i_kind = sams_pkg::KIND_PUSH;
    logic [sams_pkg::SID_W-1:0]      i_stack_id = '0;
    logic [sams_pkg::WORD_W-1:0]     i_value = '0;
    logic                            o_done;
    logic [sams_pkg::STATUS_W-1:0]   o_status;
    logic [sams_pkg::WORD_W-1:0]     o_read_value;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [sams_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [sams_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    shared_array_multi_stack_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_stack_id   (i_stack_id),
        .i_value      (i_value),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predicted stack state
    logic [sams_pkg::WORD_W-1:0] model_words [sams_pkg::DEPTH];
    int                          model_top   [sams_pkg::MAX_STACKS];
    int                          model_floor [sams_pkg::MAX_STACKS+1];
    int                          model_size;
    int                          model_count;

    t_outcome pending_outcomes [$];
    int       mismatch_count = 0;
    int       sender_idle_pct = 0;
    int       cycle_count = 0;

    function automatic logic [sams_pkg::WORD_W-1:0] get_word(input int pos);
        if (pos < 0 || pos >= sams_pkg::DEPTH) return '0;
        return model_words[pos];
    endfunction

    function automatic void put_word(input int pos, input logic [sams_pkg::WORD_W-1:0] v);
        if (pos >= 0 && pos < sams_pkg::DEPTH) model_words[pos] = v;
    endfunction

    function automatic void rebuild_layout();
        if (model_count < 1) model_count = 1;
        if (model_count > sams_pkg::MAX_STACKS) model_count = sams_pkg::MAX_STACKS;
        if (model_size < model_count) model_size = model_count;
        if (model_size > sams_pkg::DEPTH) model_size = sams_pkg::DEPTH;
        for (int s = 0; s < model_count; s++) begin
            model_top[s]   = (model_size / model_count) * s - 1;
            model_floor[s] = model_top[s];
        end
        model_floor[model_count] = model_size - 1;
    endfunction

    function automatic void apply_register_write(
        input logic [sams_pkg::CFG_IDX_W-1:0]  idx,
        input logic [sams_pkg::CFG_DATA_W-1:0] data);
        if (idx == sams_pkg::CFG_ARRAY_SIZE) model_size = int'(data);
        else if (idx == sams_pkg::CFG_STACK_COUNT) model_count = int'(data[sams_pkg::K_W-1:0]);
        else return;
        rebuild_layout();
    endfunction

    function automatic logic [sams_pkg::STATUS_W-1:0] push_word(
        input int t, input logic [sams_pkg::WORD_W-1:0] v);
        int i;
        if (model_top[t] != model_floor[t+1]) begin
            model_top[t]++;
            put_word(model_top[t], v);
            return sams_pkg::ST_OK;
        end
        // full: shift the next stack up one word to free a slot
        if (t != model_count - 1 && model_top[t+1] != model_floor[t+2]) begin
            for (i = model_top[t+1]; i > model_floor[t+1]; i--) put_word(i + 1, get_word(i));
            model_floor[t+1]++;
            model_top[t+1]++;
            model_top[t]++;
            put_word(model_top[t], v);
            return sams_pkg::ST_OK;
        end
        // otherwise slide own contents down into the previous stack's spare slot
        if (t != 0 && model_top[t-1] != model_floor[t]) begin
            for (i = model_floor[t]; i < model_top[t]; i++) put_word(i, get_word(i + 1));
            model_floor[t]--;
            put_word(model_top[t], v);
            return sams_pkg::ST_OK;
        end
        return sams_pkg::ST_OVERFLOW;
    endfunction

    function automatic t_outcome predict_command(input logic [sams_pkg::KIND_W-1:0] kind,
                                                 input logic [sams_pkg::SID_W-1:0]  sid,
                                                 input logic [sams_pkg::WORD_W-1:0] value);
        t_outcome res;
        int       s;
        logic     in_range;
        s = int'(sid);
        in_range = s < model_count;
        res = '0;
        if (kind == sams_pkg::KIND_PUSH) begin
            res.status = in_range ? push_word(s, value) : sams_pkg::ST_OVERFLOW;
        end else if (kind == sams_pkg::KIND_POP || kind == sams_pkg::KIND_PEEK) begin
            if (!in_range || model_top[s] == model_floor[s]) begin
                res.status = sams_pkg::ST_UNDERFLOW;
            end else begin
                res.read_value = get_word(model_top[s]);
                if (kind == sams_pkg::KIND_POP) model_top[s]--;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                want = pending_outcomes.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d", o_status, want.status));
                if (o_read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %h, wanted %h",
                                              o_read_value, want.read_value));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("shared_array_multi_stack_core regression: fail");
            $finish;
        end
    end

    // start stays high after acceptance so back-to-back commands need a single assignment
    task automatic send_command(input logic [sams_pkg::KIND_W-1:0] kind,
                                input logic [sams_pkg::SID_W-1:0]  sid,
                                input logic [sams_pkg::WORD_W-1:0] value);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_kind     <= kind;
        i_stack_id <= sid;
        i_value    <= value;
        do @(posedge i_clk); while (busy);
        pending_outcomes.push_back(predict_command(kind, sid, value));
    endtask

    task automatic drain_outcomes();
        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [sams_pkg::CFG_IDX_W-1:0]  idx,
                                  input logic [sams_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register_write(idx, data);
    endtask

    task automatic load_layout(input logic [sams_pkg::CFG_DATA_W-1:0] size_data,
                               input logic [sams_pkg::CFG_DATA_W-1:0] count_data);
        drain_outcomes();
        if ($urandom_range(3) == 0)
            write_register($urandom_range(1) ? CFG_SPARE_LOW : CFG_SPARE_TOP,
                           sams_pkg::CFG_DATA_W'($urandom_range(127)));
        if ($urandom_range(1)) begin
            write_register(sams_pkg::CFG_ARRAY_SIZE, size_data);
            write_register(sams_pkg::CFG_STACK_COUNT, count_data);
        end else begin
            write_register(sams_pkg::CFG_STACK_COUNT, count_data);
            write_register(sams_pkg::CFG_ARRAY_SIZE, size_data);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_layout();
        send_command(sams_pkg::KIND_PUSH, 2'd0, 32'h7fff_ffff);
        send_command(sams_pkg::KIND_PUSH, 2'd3, 32'h8000_0000);
        send_command(sams_pkg::KIND_PEEK, 2'd0, 32'h0);
        send_command(sams_pkg::KIND_POP,  2'd3, 32'hffff_ffff);
        send_command(sams_pkg::KIND_POP,  2'd3, 32'h0);
        send_command(sams_pkg::KIND_PEEK, 2'd2, 32'h0);
        send_command(KIND_NONE,           2'd1, 32'h5a5a_5a5a);
        send_command(sams_pkg::KIND_POP,  2'd0, 32'h0);
    endtask

    task automatic test_neighbour_borrow();
        drain_outcomes();
        write_register(CFG_SPARE_LOW, 7'h7f);
        write_register(CFG_SPARE_TOP, 7'h00);
        write_register(sams_pkg::CFG_ARRAY_SIZE, 7'd4);
        write_register(sams_pkg::CFG_STACK_COUNT, 7'd2);
        i_cfg_valid <= 1'b0;
        send_command(sams_pkg::KIND_PUSH, 2'd1, 32'h1111_0001);
        send_command(sams_pkg::KIND_PUSH, 2'd0, 32'h0000_0000);
        send_command(sams_pkg::KIND_PUSH, 2'd0, 32'hffff_ffff);
        // full, next stack moves up with its word
        send_command(sams_pkg::KIND_PUSH, 2'd0, 32'h2222_0003);
        send_command(sams_pkg::KIND_PUSH, 2'd0, 32'h2222_0004);
        send_command(sams_pkg::KIND_PUSH, 2'd1, 32'h1111_0002);
        send_command(sams_pkg::KIND_POP,  2'd1, 32'h0);
        send_command(sams_pkg::KIND_POP,  2'd0, 32'h0);
        send_command(sams_pkg::KIND_POP,  2'd0, 32'h0);
        send_command(sams_pkg::KIND_PUSH, 2'd1, 32'h8000_0000);
        // full last stack, slides down into the previous slice
        send_command(sams_pkg::KIND_PUSH, 2'd1, 32'h7fff_ffff);
        send_command(sams_pkg::KIND_POP,  2'd1, 32'h0);
        send_command(sams_pkg::KIND_POP,  2'd1, 32'h0);
        send_command(sams_pkg::KIND_POP,  2'd1, 32'h0);
        send_command(sams_pkg::KIND_PEEK, 2'd0, 32'h0);
        send_command(sams_pkg::KIND_PUSH, 2'd2, 32'h3333_3333);
        send_command(sams_pkg::KIND_PEEK, 2'd3, 32'h0);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int first_round,
                                       input int rounds);
        logic [sams_pkg::KIND_W-1:0] kind;
        logic [sams_pkg::SID_W-1:0]  sid;
        logic [sams_pkg::WORD_W-1:0] value;
        int                          push_share;
        int                          run_left;
        int                          roll;
        sender_idle_pct = idle_pct;
        for (int r = first_round; r < first_round + rounds; r++) begin
            case (r)
                0:       load_layout(7'd127, 7'd7);
                1:       load_layout(7'd1, 7'd1);
                2:       load_layout(7'd64, 7'd1);
                3:       load_layout(7'd64, 7'd3);
                4:       load_layout(7'd0, 7'd0);
                5:       load_layout(7'd9, 7'd4);
                default: load_layout(sams_pkg::CFG_DATA_W'($urandom_range(127)),
                                     sams_pkg::CFG_DATA_W'($urandom_range(127)));
            endcase
            run_left = 0;
            push_share = 0;
            for (int n = 0; n < ROUND_COMMANDS; n++) begin
                // pick filling or emptying runs at random so stacks reach full and borrow
                if (run_left == 0) begin
                    run_left = $urandom_range(8, 40);
                    push_share = $urandom_range(1) ? 80 : 25;
                end
                run_left--;
                roll = $urandom_range(99);
                if (roll < 3) kind = KIND_NONE;
                else if (roll < 3 + push_share) kind = sams_pkg::KIND_PUSH;
                else kind = ($urandom_range(9) < 7) ? sams_pkg::KIND_POP : sams_pkg::KIND_PEEK;
                if ($urandom_range(99) < 92)
                    sid = sams_pkg::SID_W'($urandom_range(model_count - 1));
                else
                    sid = sams_pkg::SID_W'($urandom_range(3));
                case ($urandom_range(15))
                    0:       value = 32'h8000_0000;
                    1:       value = 32'h7fff_ffff;
                    2:       value = 32'hffff_ffff;
                    3:       value = 32'h0;
                    default: value = $urandom();
                endcase
                send_command(kind, sid, value);
                if ($urandom_range(199) == 0) drain_outcomes();
            end
        end
    endtask

    initial begin
        model_size  = 64;
        model_count = 4;
        for (int i = 0; i < sams_pkg::DEPTH; i++) model_words[i] = '0;
        rebuild_layout();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_layout();
        test_neighbour_borrow();
        test_random_traffic(19, 0, 6);
        test_random_traffic(75, 6, 5);
        test_random_traffic(0, 11, RANDOM_ROUNDS - 11);

        drain_outcomes();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
            $display("shared_array_multi_stack_core regression: pass");
        end else begin
            $display("shared_array_multi_stack_core regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
